// ----- sv/scrd_pkg.sv -----
package scrd_pkg;

   localparam int unsigned SAMPLE_W   = 16;
   localparam int unsigned CENTROID_W = 11;
   localparam int unsigned COUNT_W    = 11;

   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 16'd6000;
   localparam logic [COUNT_W-1:0]  COUNT_MAX       = 11'd2047;

   typedef enum logic {
      KIND_CENTROID = 1'b0,
      KIND_COUNT    = 1'b1
   } result_kind_type;

   // One result transaction as it sits in the output register.
   typedef struct packed {
      result_kind_type         kind;
      logic                    last;
      logic [COUNT_W-1:0]      count;
      logic [CENTROID_W-1:0]   centroid;
   } result_type;

endpackage

// ----- sv/scrd_div.sv -----
module scrd_div #(
   parameter int unsigned NUM_W = 22,
   parameter int unsigned DEN_W = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             busy,
   output logic [NUM_W-1:0] quotient
);

   localparam int unsigned STEP_W = $clog2(NUM_W + 1);

   logic [STEP_W-1:0] step_ff, step_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;

   // Restoring division, one quotient bit per cycle, dividend shifted out
   // of the top of the quotient register as quotient bits enter below.
   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         step_in = STEP_W'(NUM_W);
         quo_in  = numer;
         rem_in  = '0;
         den_in  = denom;
      end else if (step_ff != '0) begin
         step_in = step_ff - 1'b1;
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy     = (step_ff != '0);
   assign quotient = quo_ff;

endmodule

// ----- sv/scan_run_centroid_detector.sv -----
// Channel   Direction  Handshake                 Contents
// req       in         req_tvalid / req_tready   one intensity sample, tlast ends the scan
// rsp       out        rsp_tvalid / rsp_tready   centroid report or end of scan run count
// csr       in         csr_wen (no back-pressure) run threshold
//
// After a plain sample the block is ready for the next one; one that only ends the scan first
// sends the run count. A sample that closes a run starts the bit-serial divider on the index
// sum (2 * clog2(MAX_SAMPLES) bits, 22 by default) and holds off samples until the centroid,
// and the run count if it also ends the scan, are sent; rsp_tready held low delays this.
// Reset is synchronous and active high; it clears all scan state and loads the threshold
// with 6000. The next sample is accepted while a finished result waits in the output register.
module scan_run_centroid_detector
   import scrd_pkg::*;
#(
   parameter int unsigned MAX_SAMPLES = 2048
) (
   input  logic        clock,
   input  logic        reset,
   // Sample channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] intensity
   input  logic        req_tlast,   // scan_end
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [10:0] centroid_index, [21:11] run_count, zero pad
   output logic        rsp_tuser,   // result_kind
   output logic        rsp_tlast,   // last_result
   // Configuration.
   input  logic        csr_wen,
   input  logic [15:0] csr_wdata    // run_threshold
);

   // Index of the next sample, saturating at MAX_SAMPLES.
   localparam int unsigned IDX_W = $clog2(MAX_SAMPLES + 1);
   // The sum of all indices of one scan stays below 2^(2*clog2(MAX_SAMPLES)).
   localparam int unsigned SUM_W = 2 * $clog2(MAX_SAMPLES);
   localparam int unsigned LEN_W = IDX_W;
   localparam int unsigned CEN_W = (SUM_W > CENTROID_W) ? SUM_W : CENTROID_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SEND_CENT,
      ST_SEND_COUNT
   } state_type;

   state_type            state_ff, state_in;
   logic [SAMPLE_W-1:0]  threshold_ff, threshold_in;
   logic                 in_run_ff, in_run_in;
   logic [IDX_W-1:0]     sample_index_ff, sample_index_in;
   logic [SUM_W-1:0]     index_sum_ff, index_sum_in;
   logic [LEN_W-1:0]     run_length_ff, run_length_in;
   logic [COUNT_W-1:0]   runs_closed_ff, runs_closed_in;
   // Count to report with the pending results and whether the scan ended.
   logic [COUNT_W-1:0]   report_count_ff, report_count_in;
   logic                 scan_end_ff, scan_end_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_ff, rsp_in;

   logic                 accept;
   logic                 in_range;
   logic                 above;
   logic                 closes;
   logic [COUNT_W-1:0]   closed_next;
   logic                 out_free;
   logic                 div_start;
   logic                 div_busy;
   logic [SUM_W-1:0]     div_quotient;
   logic [CEN_W-1:0]     centroid_wide;

   scrd_div #(
      .NUM_W (SUM_W),
      .DEN_W (LEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (index_sum_ff),
      .denom    (run_length_ff),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   assign req_tready    = (state_ff == ST_IDLE);
   assign accept        = req_tvalid && req_tready;
   assign out_free      = !rsp_valid_ff || rsp_tready;
   assign in_range      = (sample_index_ff < IDX_W'(MAX_SAMPLES));
   assign above         = (req_tdata > threshold_ff);
   // A sample at or below the threshold closes an open run.
   assign closes        = in_range && !above && in_run_ff;
   assign div_start     = accept && closes;
   assign closed_next   = (runs_closed_ff < COUNT_MAX) ? runs_closed_ff + 1'b1
                                                       : runs_closed_ff;
   // Centroids wider than the output field are reported modulo 2^11.
   assign centroid_wide = CEN_W'(div_quotient);

   always_comb begin
      state_in        = state_ff;
      threshold_in    = threshold_ff;
      in_run_in       = in_run_ff;
      sample_index_in = sample_index_ff;
      index_sum_in    = index_sum_ff;
      run_length_in   = run_length_ff;
      runs_closed_in  = runs_closed_ff;
      report_count_in = report_count_ff;
      scan_end_in     = scan_end_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;

      if (csr_wen) begin
         threshold_in = csr_wdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               scan_end_in = req_tlast;
               if (in_range) begin
                  sample_index_in = sample_index_ff + 1'b1;
                  if (above) begin
                     in_run_in     = 1'b1;
                     index_sum_in  = index_sum_ff + SUM_W'(sample_index_ff);
                     run_length_in = run_length_ff + 1'b1;
                  end else if (in_run_ff) begin
                     // The divider has latched sum and length at this edge.
                     in_run_in      = 1'b0;
                     index_sum_in   = '0;
                     run_length_in  = '0;
                     runs_closed_in = closed_next;
                  end
               end
               report_count_in = closes ? closed_next : runs_closed_ff;
               if (req_tlast) begin
                  // An open run is dropped at the end of the scan.
                  in_run_in       = 1'b0;
                  sample_index_in = '0;
                  index_sum_in    = '0;
                  run_length_in   = '0;
                  runs_closed_in  = '0;
               end
               if (closes) begin
                  state_in = ST_DIVIDE;
               end else if (req_tlast) begin
                  state_in = ST_SEND_COUNT;
               end
            end
         end
         ST_DIVIDE: begin
            if (!div_busy) begin
               state_in = ST_SEND_CENT;
            end
         end
         ST_SEND_CENT: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.kind     = KIND_CENTROID;
               rsp_in.last     = !scan_end_ff;
               rsp_in.count    = report_count_ff;
               rsp_in.centroid = centroid_wide[CENTROID_W-1:0];
               state_in        = scan_end_ff ? ST_SEND_COUNT : ST_IDLE;
            end
         end
         ST_SEND_COUNT: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.kind     = KIND_COUNT;
               rsp_in.last     = 1'b1;
               rsp_in.count    = report_count_ff;
               rsp_in.centroid = '0;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         threshold_ff    <= THRESHOLD_RESET;
         in_run_ff       <= 1'b0;
         sample_index_ff <= '0;
         index_sum_ff    <= '0;
         run_length_ff   <= '0;
         runs_closed_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         threshold_ff    <= threshold_in;
         in_run_ff       <= in_run_in;
         sample_index_ff <= sample_index_in;
         index_sum_ff    <= index_sum_in;
         run_length_ff   <= run_length_in;
         runs_closed_ff  <= runs_closed_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      report_count_ff <= report_count_in;
      scan_end_ff     <= scan_end_in;
      rsp_ff          <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.count, rsp_ff.centroid};
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;

endmodule

// ----- dv/scan_run_centroid_detector_tb.sv -----
`timescale 1ns / 100ps

// Self-checking bench for the scan run centroid detector.
//
// The sample channel is fed by a clocked driver that draws scan samples from a backlog
// queue filled by the stimulus block. Every sample transaction that the block accepts is
// replayed at the same clock edge through a scan tracker, which mirrors the run state and
// queues the centroid and run count reports that the sample must cause. A clocked monitor
// pops the oldest awaited report for every result transaction and compares it field by
// field. Both channels idle at random, and a watchdog ends the run if the handshakes stop.
module scan_run_centroid_detector_tb;
   import scrd_pkg::*;

   localparam int unsigned MAX_SAMPLES    = 2048;
   localparam int unsigned INDEX_W        = 12;
   localparam int unsigned SUM_W          = 22;
   // Long enough for a full division and the result states around it, so this comfortably
   // covers any transaction that is still being worked on after the last report arrives.
   localparam int unsigned SETTLE_CYCLES  = 40;
   // Long enough for the output register and the divider to fill and stall the input.
   localparam int unsigned LONG_HOLD      = 400;
   // Well above the longest quiet stretch of a correct run: the long hold, a long gap and
   // a full division back to back.
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   // Far above the length of a whole correct run under the longest stalls.
   localparam int unsigned RUN_LIMIT      = 400000;
   localparam int unsigned MAX_PRINTED    = 40;

   typedef struct packed {
      logic [SAMPLE_W-1:0] intensity;
      logic                scan_end;
   } scan_sample_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [15:0] intensity
   logic        req_tlast = 1'b0; // scan_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [10:0] centroid_index, [21:11] run_count, zero pad
   logic        rsp_tuser;        // result_kind
   logic        rsp_tlast;        // last_result
   logic        csr_wen = 1'b0;
   logic [15:0] csr_wdata = '0;   // run_threshold

   scan_run_centroid_detector #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Samples waiting for the driver, and the count of those not yet accepted (including the
   // one currently offered on the channel).
   scan_sample_type sample_backlog[$];
   int unsigned     samples_in_flight = 0;
   result_type      awaited_reports[$];
   int unsigned     mismatch_count = 0;

   // Idling control shared by both sides; the stimulus switches it per phase so that some
   // stretches run at full rate.
   logic           idle_enable = 1'b1;
   logic           hold_request = 1'b0;
   int unsigned    send_gap = 0;
   int unsigned    stall_left = 0;
   int unsigned    quiet_cycles = 0;
   int unsigned    total_cycles = 0;

   // Mirror of the block's register and scan state.
   logic [SAMPLE_W-1:0] run_threshold_q;
   logic                in_run_q;
   logic [INDEX_W-1:0]  next_index_q;
   logic [SUM_W-1:0]    index_sum_q;
   logic [INDEX_W-1:0]  run_length_q;
   logic [COUNT_W-1:0]  runs_closed_q;

   task automatic flag_mismatch(input string what);
      if (mismatch_count < MAX_PRINTED)
         $display("%0t ns: mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   function automatic void clear_scan_state();
      in_run_q      = 1'b0;
      next_index_q  = '0;
      index_sum_q   = '0;
      run_length_q  = '0;
      runs_closed_q = '0;
   endfunction

   // Works out the reports caused by one accepted sample and queues them in order.
   function automatic void track_sample(input logic [SAMPLE_W-1:0] intensity,
                                        input logic scan_end);
      result_type       report;
      logic [SUM_W-1:0] quotient;
      if (next_index_q < MAX_SAMPLES) begin
         if (intensity > run_threshold_q) begin
            in_run_q     = 1'b1;
            index_sum_q  = index_sum_q + next_index_q;
            run_length_q = run_length_q + 1'b1;
         end else if (in_run_q) begin
            if (runs_closed_q < COUNT_MAX)
               runs_closed_q = runs_closed_q + 1'b1;
            quotient        = index_sum_q / {{(SUM_W-INDEX_W){1'b0}}, run_length_q};
            report.kind     = KIND_CENTROID;
            report.centroid = quotient[CENTROID_W-1:0];
            report.count    = runs_closed_q;
            // The run count follows on the same sample when it ends the scan.
            report.last     = !scan_end;
            awaited_reports = {awaited_reports, report};
            in_run_q     = 1'b0;
            index_sum_q  = '0;
            run_length_q = '0;
         end
         next_index_q = next_index_q + 1'b1;
      end
      // Samples past the end of the index range still end the scan.
      if (scan_end) begin
         report.kind     = KIND_COUNT;
         report.centroid = '0;
         report.count    = runs_closed_q;
         report.last     = 1'b1;
         awaited_reports = {awaited_reports, report};
         clear_scan_state();
      end
   endfunction

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99, 0);
      if (!idle_enable || roll < 60)
         return 0;
      if (roll < 90)
         return $urandom_range(3, 1);
      if (roll < 98)
         return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // Sample driver. A transaction stays on the channel until it is accepted; only then is
   // it handed to the tracker and a gap before the next one chosen.
   always @(posedge clock) begin : drive_samples
      scan_sample_type next_sample;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            track_sample(req_tdata[SAMPLE_W-1:0], req_tlast);
            samples_in_flight--;
            send_gap = pick_gap();
         end
         if (!(req_tvalid && !req_tready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (sample_backlog.size() > 0) begin
               next_sample = sample_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_sample.intensity;
               req_tlast  <= next_sample.scan_end;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and receiver. A requested long hold is counted out here while the
   // driver keeps offering samples.
   always @(posedge clock) begin : check_reports
      result_type  want;
      int unsigned stall;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_reports.size() == 0) begin
               flag_mismatch($sformatf("unexpected result: kind %0d centroid %0d count %0d last %0d",
                                       rsp_tuser, rsp_tdata[10:0], rsp_tdata[21:11], rsp_tlast));
            end else begin
               want = awaited_reports.pop_front();
               if (rsp_tuser !== want.kind)
                  flag_mismatch($sformatf("result_kind %0d, expected %0d", rsp_tuser, want.kind));
               if (rsp_tdata[10:0] !== want.centroid)
                  flag_mismatch($sformatf("centroid_index %0d, expected %0d",
                                          rsp_tdata[10:0], want.centroid));
               if (rsp_tdata[21:11] !== want.count)
                  flag_mismatch($sformatf("run_count %0d, expected %0d",
                                          rsp_tdata[21:11], want.count));
               if (rsp_tdata[23:22] !== 2'b00)
                  flag_mismatch($sformatf("tdata padding %b is not zero", rsp_tdata[23:22]));
               if (rsp_tlast !== want.last)
                  flag_mismatch($sformatf("last_result %0d, expected %0d", rsp_tlast, want.last));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            stall_left = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else begin
            stall = pick_gap();
            if (stall == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               stall_left = stall - 1;
               rsp_tready <= 1'b0;
            end
         end
      end
   end

   // Ends the run if neither channel completes a transaction for too long, or if the run
   // as a whole goes on far beyond its expected length.
   always @(posedge clock) begin
      total_cycles <= total_cycles + 1;
      if (total_cycles == RUN_LIMIT) begin
         $display("scan_run_centroid_detector verification failed");
         $finish;
      end
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("scan_run_centroid_detector verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_sample(input logic [SAMPLE_W-1:0] intensity, input logic scan_end);
      scan_sample_type item;
      item.intensity = intensity;
      item.scan_end  = scan_end;
      sample_backlog = {sample_backlog, item};
      samples_in_flight++;
   endtask

   // A level that opens or extends a run, now and then exactly one above the threshold.
   // With the threshold at its top no such level exists and the top value is returned.
   function automatic logic [SAMPLE_W-1:0] level_above();
      int unsigned         floor_level;
      logic [SAMPLE_W-1:0] level;
      floor_level = int'(run_threshold_q) + 1;
      if (run_threshold_q == '1)
         return '1;
      if ($urandom_range(9, 0) == 0)
         level = SAMPLE_W'(floor_level);
      else
         level = SAMPLE_W'($urandom_range(65535, floor_level));
      return level;
   endfunction

   // A level that closes a run, now and then exactly at the threshold.
   function automatic logic [SAMPLE_W-1:0] level_below();
      logic [SAMPLE_W-1:0] level;
      if ($urandom_range(9, 0) == 0)
         level = run_threshold_q;
      else
         level = SAMPLE_W'($urandom_range(int'(run_threshold_q), 0));
      return level;
   endfunction

   // One scan of random runs: the level flips between above and below with a fixed chance,
   // so runs of every short length and scans ending inside or outside a run all occur.
   task automatic queue_scan(input int unsigned length);
      logic high;
      high = ($urandom_range(1, 0) == 1);
      for (int unsigned i = 0; i < length; i++) begin
         if ($urandom_range(99, 0) < 35)
            high = !high;
         push_sample(high ? level_above() : level_below(), i == length - 1);
      end
   endtask

   // The sender pauses here until every awaited report has come back, then lets the block
   // finish any transaction that causes no report.
   task automatic wait_until_drained();
      while (samples_in_flight != 0 || awaited_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Only called while the block is idle, so the tracker may take the new value at once.
   task automatic write_threshold(input logic [SAMPLE_W-1:0] value);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      run_threshold_q = value;
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   initial begin : stimulus
      int unsigned         phase_items;
      int unsigned         length;
      logic [SAMPLE_W-1:0] phase_threshold;

      run_threshold_q = THRESHOLD_RESET;
      clear_scan_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset threshold. A scan of one sample below the threshold.
      push_sample(16'd0, 1'b1);
      // A scan of one sample above it: the open run is discarded and the count is zero.
      push_sample(16'hFFFF, 1'b1);
      // A two sample run closed exactly at the threshold, then a second two sample run
      // closed by the sample that ends the scan, giving a centroid and a count together.
      push_sample(16'hFFFF, 1'b0);
      push_sample(THRESHOLD_RESET + 1'b1, 1'b0);
      push_sample(THRESHOLD_RESET, 1'b0);
      push_sample(16'h5555, 1'b0);
      push_sample(16'hAAAA, 1'b0);
      push_sample(THRESHOLD_RESET, 1'b1);
      // A run still open when the scan ends.
      push_sample(16'h0000, 1'b0);
      push_sample(THRESHOLD_RESET + 1'b1, 1'b0);
      push_sample(16'hFFFF, 1'b1);
      wait_until_drained();

      // With the threshold at zero only a zero intensity closes a run.
      write_threshold(16'd0);
      push_sample(16'd0, 1'b0);
      push_sample(16'd1, 1'b0);
      push_sample(16'd0, 1'b0);
      push_sample(16'hFFFF, 1'b1);
      wait_until_drained();

      // With the threshold at its top nothing opens a run.
      write_threshold(16'hFFFF);
      push_sample(16'hFFFF, 1'b0);
      push_sample(16'hFFFF, 1'b1);
      wait_until_drained();

      // Random phases, each under its own threshold, extremes first.
      for (int unsigned phase = 0; phase < 9; phase++) begin
         case (phase)
            0:       phase_threshold = THRESHOLD_RESET;
            1:       phase_threshold = 16'd0;
            2:       phase_threshold = 16'hFFFF;
            3:       phase_threshold = 16'd1;
            4:       phase_threshold = 16'hFFFE;
            default: phase_threshold = $urandom_range(65535, 0);
         endcase
         write_threshold(phase_threshold);
         idle_enable = !(phase == 3 || phase == 6);
         // Under the reset threshold most samples start runs, so holding the receiver off
         // here fills the block and stalls the sample channel.
         if (phase == 0)
            hold_request = 1'b1;
         phase_items = 0;
         while (phase_items < 42) begin
            if ($urandom_range(99, 0) < 85)
               length = $urandom_range(20, 1);
            else
               length = $urandom_range(80, 21);
            queue_scan(length);
            phase_items += length;
         end
         wait_until_drained();
      end

      if (awaited_reports.size() != 0)
         flag_mismatch($sformatf("%0d reports never arrived", awaited_reports.size()));
      if (mismatch_count == 0)
         $display("scan_run_centroid_detector verification clean");
      else
         $display("scan_run_centroid_detector verification failed");
      $finish;
   end

endmodule
